/* hdl/ffpa_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit pool allocator package
// Shared opcodes, status codes, sequencer states and constants.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned HdrBytes  = 8;
  localparam int unsigned DataAlign = 16;
  localparam int unsigned SizeAlign = 4;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_BAD_SIZE = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_RSZ_RD,
    S_RSZ_CHK,
    S_FIT_RD,
    S_FIT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_DEL_RD,
    S_DEL_WR,
    S_REFIND,
    S_DONE
  } state_e;

endpackage

/* hdl/ffpa_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload of generic type between a source and a sink.
// ----------------------------------------------------------------------------
interface ffpa_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/ffpa_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/first_fit_pool_allocator.sv */
// Each request walks the block table in address order, one entry at a time,
// through one shared table address; entries are moved one by one on insert
// or removal, and one request is taken at a time.
// Reset clears the block count, sequencer state and output valid only; table contents are unknown until written.
// ----------------------------------------------------------------------------
// First-fit pool allocator
// Allocates, frees and resizes blocks in a pool by first fit.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator #(
  parameter int unsigned POOL_BYTES = 65536,
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] data_offset_i,
  input  logic [16:0] request_bytes_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [15:0] result_offset_o,
  output logic [2:0]  status_o
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OW = $clog2(POOL_BYTES) + 2;

  typedef logic [OW-1:0] off_t;

  localparam off_t Pool = off_t'(POOL_BYTES);
  localparam off_t Hdr  = off_t'(ffpa_pkg::HdrBytes);
  localparam off_t Mask = off_t'(ffpa_pkg::DataAlign - 1);

  ffpa_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [1:0]  op_q, op_d;
  logic [15:0] off_q, off_d;
  logic [16:0] req_q, req_d;
  logic [15:0] res_q, res_d;
  logic [2:0]  st_q, st_d;
  off_t        end_q, end_d;
  off_t        hdr_q, hdr_d;
  logic        out_v_q, out_v_d;

  // Table memories: header offset and size share one address.
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  off_t           wh, rh;
  logic [16:0]    wb, rb;

  ffpa_ram #(.Width(OW), .Depth(MAX_BLOCKS)) u_hdr (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wh), .raddr_i(raddr), .rdata_o(rh)
  );
  ffpa_ram #(.Width(17), .Depth(MAX_BLOCKS)) u_size (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wb), .raddr_i(raddr), .rdata_o(rb)
  );

  function automatic off_t foot(logic [16:0] s);
    foot = Hdr + off_t'(s) + ((s[1:0] != 2'd0) ? off_t'(ffpa_pkg::SizeAlign) : '0);
  endfunction

  // Shared arithmetic: spot after the current end and comparison with limit.
  off_t spot_rnd, spot_hdr, limit, need;
  logic spot_ok, fits;
  always_comb begin
    spot_rnd = (end_q + Hdr + Mask) & ~Mask;
    spot_hdr = spot_rnd - Hdr;
    limit    = (idx_q < count_q) ? rh : Pool;
    need     = foot(req_q);
    spot_ok  = spot_rnd < Pool;
    fits     = spot_ok && (spot_hdr <= limit) && ((limit - spot_hdr) >= need);
  end

  assign in_ready_o      = (state_q == ffpa_pkg::S_IDLE) && !out_v_q;
  assign out_valid_o     = out_v_q;
  assign result_offset_o = res_q;
  assign status_o        = st_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffpa_pkg::S_IDLE;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    op_q  <= op_d;
    off_q <= off_d;
    req_q <= req_d;
    res_q <= res_d;
    st_q  <= st_d;
    end_q <= end_d;
    hdr_q <= hdr_d;
  end

  // Sequencer.
  always_comb begin
    logic bad;
    state_d = state_q;
    count_d = count_q;
    out_v_d = out_v_q;
    idx_d = idx_q;
    pos_d = pos_q;
    op_d  = op_q;
    off_d = off_q;
    req_d = req_q;
    res_d = res_q;
    st_d  = st_q;
    end_d = end_q;
    hdr_d = hdr_q;
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    raddr = idx_q[AW-1:0];
    wh    = hdr_q;
    wb    = req_q;
    bad   = (req_q == 17'd0) || (32'(req_q) > POOL_BYTES);
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    unique case (state_q)
      ffpa_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          op_d  = opcode_i;
          off_d = data_offset_i;
          req_d = request_bytes_i;
          res_d = '0;
          st_d  = ffpa_pkg::ST_OK;
          idx_d = '0;
          state_d = ffpa_pkg::S_DONE;
          if (opcode_i == ffpa_pkg::OP_ALLOC ||
              (opcode_i == ffpa_pkg::OP_RESIZE && data_offset_i == 16'd0)) begin
            state_d = ffpa_pkg::S_FIT_RD;
          end else if (opcode_i == ffpa_pkg::OP_FREE && data_offset_i != 16'd0) begin
            state_d = ffpa_pkg::S_FIND_RD;
          end else if (opcode_i == ffpa_pkg::OP_RESIZE) begin
            state_d = ffpa_pkg::S_FIND_RD;
          end
        end
      end
      ffpa_pkg::S_FIND_RD: begin
        if (op_q == ffpa_pkg::OP_RESIZE && bad) begin
          st_d = ffpa_pkg::ST_BAD_SIZE;
          state_d = ffpa_pkg::S_DONE;
        end else if (idx_q >= count_q) begin
          st_d = ffpa_pkg::ST_UNKNOWN;
          state_d = ffpa_pkg::S_DONE;
        end else begin
          state_d = ffpa_pkg::S_FIND_CHK;
        end
      end
      ffpa_pkg::S_FIND_CHK: begin
        if (rh + Hdr == off_t'(off_q)) begin
          pos_d = idx_q;
          hdr_d = rh;
          if (op_q == ffpa_pkg::OP_FREE) begin
            state_d = ffpa_pkg::S_DEL_RD;
            idx_d = idx_q + CW'(1);
          end else begin
            idx_d = idx_q + CW'(1);
            state_d = ffpa_pkg::S_RSZ_RD;
          end
        end else begin
          idx_d = idx_q + CW'(1);
          state_d = ffpa_pkg::S_FIND_RD;
        end
      end
      ffpa_pkg::S_RSZ_RD: begin
        state_d = ffpa_pkg::S_RSZ_CHK;
      end
      ffpa_pkg::S_RSZ_CHK: begin
        // limit comes from the next entry or the pool end
        if (hdr_q + foot(req_q) <= limit) begin
          we    = 1'b1;
          waddr = pos_q[AW-1:0];
          wb    = req_q;
          res_d = off_q;
          state_d = ffpa_pkg::S_DONE;
        end else begin
          idx_d = '0;
          state_d = ffpa_pkg::S_FIT_RD;
        end
      end
      ffpa_pkg::S_FIT_RD: begin
        if (bad) begin
          st_d = ffpa_pkg::ST_BAD_SIZE;
          state_d = ffpa_pkg::S_DONE;
        end else if (count_q >= CW'(MAX_BLOCKS)) begin
          st_d = ffpa_pkg::ST_FULL;
          state_d = ffpa_pkg::S_DONE;
        end else begin
          // The head spot follows offset zero; later spots follow the previous block.
          if (idx_q == '0) begin
            end_d = '0;
          end
          state_d = ffpa_pkg::S_FIT_CHK;
        end
      end
      ffpa_pkg::S_FIT_CHK: begin
        if (fits) begin
          hdr_d = spot_hdr;
          pos_d = idx_q;
          idx_d = count_q;
          res_d = 16'(spot_hdr + Hdr);
          state_d = (count_q == idx_q) ? ffpa_pkg::S_INSERT : ffpa_pkg::S_SHIFT_RD;
        end else if (idx_q >= count_q) begin
          st_d = ffpa_pkg::ST_NO_SPACE;
          state_d = ffpa_pkg::S_DONE;
        end else begin
          end_d = rh + foot(rb);
          idx_d = idx_q + CW'(1);
          state_d = ffpa_pkg::S_FIT_RD;
        end
      end
      ffpa_pkg::S_SHIFT_RD: begin
        raddr = AW'(idx_q - CW'(1));
        state_d = ffpa_pkg::S_SHIFT_WR;
      end
      ffpa_pkg::S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        wh    = rh;
        wb    = rb;
        idx_d = idx_q - CW'(1);
        state_d = (idx_q - CW'(1) == pos_q) ? ffpa_pkg::S_INSERT : ffpa_pkg::S_SHIFT_RD;
      end
      ffpa_pkg::S_INSERT: begin
        we    = 1'b1;
        waddr = pos_q[AW-1:0];
        wh    = hdr_q;
        wb    = req_q;
        count_d = count_q + CW'(1);
        if (op_q == ffpa_pkg::OP_RESIZE && off_q != 16'd0) begin
          idx_d = '0;
          state_d = ffpa_pkg::S_REFIND;
        end else begin
          state_d = ffpa_pkg::S_DONE;
        end
      end
      ffpa_pkg::S_REFIND: begin
        state_d = ffpa_pkg::S_FIND_CHK;
        op_d = ffpa_pkg::OP_FREE;
      end
      ffpa_pkg::S_DEL_RD: begin
        if (idx_q >= count_q) begin
          count_d = count_q - CW'(1);
          state_d = ffpa_pkg::S_DONE;
        end else begin
          state_d = ffpa_pkg::S_DEL_WR;
        end
      end
      ffpa_pkg::S_DEL_WR: begin
        we    = 1'b1;
        waddr = AW'(idx_q - CW'(1));
        wh    = rh;
        wb    = rb;
        idx_d = idx_q + CW'(1);
        state_d = ffpa_pkg::S_DEL_RD;
      end
      ffpa_pkg::S_DONE: begin
        if (!out_v_q) begin
          out_v_d = 1'b1;
          state_d = ffpa_pkg::S_IDLE;
        end
      end
      default: state_d = ffpa_pkg::S_IDLE;
    endcase
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit pool allocator testbench
// Drives allocate, free, resize and no-op requests with random idling on both
// channels. Expected offsets and status codes come from a cycle-free model of
// the block table. Each response transfer is checked in order against them.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PoolBytes = 65536;
  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    ffpa_pkg::op_e opcode;
    logic [15:0]   data_offset;
    logic [16:0]   request_bytes;
  } request_t;

  typedef struct packed {
    logic [15:0] result_offset;
    logic [2:0]  status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ffpa_if #(.payload_t(request_t)) req_ch ();
  ffpa_if #(.payload_t(answer_t))  ans_ch ();

  first_fit_pool_allocator #(
    .POOL_BYTES(PoolBytes),
    .MAX_BLOCKS(MaxBlocks)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_ch.valid),
    .in_ready_o     (req_ch.ready),
    .opcode_i       (req_ch.payload.opcode),
    .data_offset_i  (req_ch.payload.data_offset),
    .request_bytes_i(req_ch.payload.request_bytes),
    .out_valid_o    (ans_ch.valid),
    .out_ready_i    (ans_ch.ready),
    .result_offset_o(ans_ch.payload.result_offset),
    .status_o       (ans_ch.payload.status)
  );

  // Model of the block table, in address order.
  longint unsigned blk_hdr [MaxBlocks];
  longint unsigned blk_len [MaxBlocks];
  int unsigned     blk_cnt = 0;

  request_t pending_q[$];
  answer_t  expected_q[$];
  answer_t  check_q[$];
  answer_t  staged_q[$];
  bit       stimulus_done = 1'b0;
  int       fail_count = 0;
  int       quiet_cycles = 0;

  function automatic longint unsigned pad_of(longint unsigned s);
    return (s & 3) != 0 ? 4 : 0;
  endfunction

  function automatic int find_blk(longint unsigned off);
    for (int i = 0; i < blk_cnt; i++) begin
      if (blk_hdr[i] + ffpa_pkg::HdrBytes == off) return i;
    end
    return -1;
  endfunction

  function automatic void drop_blk(int idx);
    for (int i = idx; i + 1 < blk_cnt; i++) begin
      blk_hdr[i] = blk_hdr[i + 1];
      blk_len[i] = blk_len[i + 1];
    end
    blk_cnt--;
  endfunction

  // First fit over the head spot and the spot after every block.
  function automatic ffpa_pkg::status_e place_blk(longint unsigned size,
                                                  output longint unsigned off);
    longint unsigned need, fin, lim, p, h;
    off = 0;
    if (size == 0 || size > PoolBytes) return ffpa_pkg::ST_BAD_SIZE;
    if (blk_cnt >= MaxBlocks) return ffpa_pkg::ST_FULL;
    need = ffpa_pkg::HdrBytes + size + pad_of(size);
    for (int k = 0; k <= blk_cnt; k++) begin
      fin = (k == 0) ? 0 : blk_hdr[k - 1] + ffpa_pkg::HdrBytes + blk_len[k - 1]
                           + pad_of(blk_len[k - 1]);
      lim = (k < blk_cnt) ? blk_hdr[k] : PoolBytes;
      p = (fin + ffpa_pkg::HdrBytes + ffpa_pkg::DataAlign - 1)
          & ~(longint'(ffpa_pkg::DataAlign - 1));
      if (p >= PoolBytes) continue;
      h = p - ffpa_pkg::HdrBytes;
      if (h > lim || lim - h < need) continue;
      for (int i = blk_cnt; i > k; i--) begin
        blk_hdr[i] = blk_hdr[i - 1];
        blk_len[i] = blk_len[i - 1];
      end
      blk_hdr[k] = h;
      blk_len[k] = size;
      blk_cnt++;
      off = h + ffpa_pkg::HdrBytes;
      return ffpa_pkg::ST_OK;
    end
    return ffpa_pkg::ST_NO_SPACE;
  endfunction

  // Applies one request to the model and returns the expected answer.
  function automatic answer_t allocate_answer(request_t rq);
    answer_t a;
    longint unsigned res, off, req, lim, fin;
    ffpa_pkg::status_e st;
    int idx;
    res = 0;
    st = ffpa_pkg::ST_OK;
    off = rq.data_offset;
    req = rq.request_bytes;
    case (rq.opcode)
      ffpa_pkg::OP_ALLOC: st = place_blk(req, res);
      ffpa_pkg::OP_FREE: begin
        if (off != 0) begin
          idx = find_blk(off);
          if (idx < 0) st = ffpa_pkg::ST_UNKNOWN;
          else drop_blk(idx);
        end
      end
      ffpa_pkg::OP_RESIZE: begin
        if (off == 0) begin
          st = place_blk(req, res);
        end else if (req == 0 || req > PoolBytes) begin
          st = ffpa_pkg::ST_BAD_SIZE;
        end else begin
          idx = find_blk(off);
          if (idx < 0) begin
            st = ffpa_pkg::ST_UNKNOWN;
          end else begin
            fin = blk_hdr[idx] + ffpa_pkg::HdrBytes + req + pad_of(req);
            lim = (idx + 1 < blk_cnt) ? blk_hdr[idx + 1] : PoolBytes;
            if (fin <= lim) begin
              blk_len[idx] = req;
              res = off;
            end else begin
              st = place_blk(req, res);
              if (st == ffpa_pkg::ST_OK) begin
                idx = find_blk(off);
                if (idx >= 0) drop_blk(idx);
              end
            end
          end
        end
      end
      default: ;
    endcase
    a.result_offset = res[15:0];
    a.status = st;
    return a;
  endfunction

  function automatic void queue_request(ffpa_pkg::op_e op, int unsigned off,
                                        int unsigned req);
    request_t rq;
    rq.opcode = op;
    rq.data_offset = off[15:0];
    rq.request_bytes = req[16:0];
    pending_q.push_back(rq);
    expected_q.push_back(allocate_answer(rq));
  endfunction

  // Data offset of a random stored block, or zero when the pool is empty.
  function automatic int unsigned live_offset();
    if (blk_cnt == 0) return 0;
    return 32'(blk_hdr[$urandom_range(0, blk_cnt - 1)] + ffpa_pkg::HdrBytes);
  endfunction

  function automatic int unsigned random_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 64);
    if (r < 90) return $urandom_range(65, 2048);
    if (r < 96) return $urandom_range(2049, PoolBytes);
    if (r < 98) return 0;
    return $urandom_range(PoolBytes + 1, 131071);
  endfunction

  // Idle lengths: mostly none or short, a few long.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Clock and reset.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Request driver with random gaps; a burst mode turns idling off.
  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      send_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if ($urandom_range(0, 199) == 0) send_burst <= ~send_burst;
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        req_ch.payload <= pending_q.pop_front();
        req_ch.valid <= 1'b1;
        send_gap <= send_burst ? 0 : idle_length();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response monitor with random back-pressure.
  int unsigned hold_gap = 0;
  answer_t     want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ans_ch.ready <= 1'b0;
      hold_gap <= 0;
    end else begin
      if (ans_ch.valid && ans_ch.ready) begin
        if (check_q.size() == 0) begin
          $error("unexpected transfer: result_offset %0d status %0d",
                 ans_ch.payload.result_offset, ans_ch.payload.status);
          fail_count++;
        end else begin
          want = check_q.pop_front();
          if (ans_ch.payload.result_offset !== want.result_offset) begin
            $error("result_offset: expected %0d, got %0d",
                   want.result_offset, ans_ch.payload.result_offset);
            fail_count++;
          end
          if (ans_ch.payload.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, ans_ch.payload.status);
            fail_count++;
          end
        end
      end
      if (hold_gap != 0) begin
        hold_gap <= hold_gap - 1;
        ans_ch.ready <= 1'b0;
      end else begin
        ans_ch.ready <= 1'b1;
        hold_gap <= send_burst ? 0 : idle_length();
      end
    end
  end

  // Expectations move to the check queue once their request is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) check_q.push_back(staged_q.pop_front());
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (ans_ch.valid && ans_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Stimulus: directed corner cases, then random traffic.
  initial begin
    int unsigned r, off, n;
    // Directed part.
    queue_request(ffpa_pkg::OP_ALLOC, 0, 0);
    queue_request(ffpa_pkg::OP_ALLOC, 0, PoolBytes + 1);
    queue_request(ffpa_pkg::OP_ALLOC, 0, 131071);
    queue_request(ffpa_pkg::OP_ALLOC, 0, 1);
    queue_request(ffpa_pkg::OP_ALLOC, 0, 4);
    queue_request(ffpa_pkg::OP_ALLOC, 0, 13);
    queue_request(ffpa_pkg::OP_FREE, 0, 0);
    queue_request(ffpa_pkg::OP_FREE, 16'hFFFF, 0);
    queue_request(ffpa_pkg::OP_RESIZE, 16'hAAAA, 20);
    queue_request(ffpa_pkg::OP_RESIZE, 8, 0);
    queue_request(ffpa_pkg::OP_RESIZE, 8, PoolBytes + 1);
    queue_request(ffpa_pkg::OP_RESIZE, 8, 7);
    queue_request(ffpa_pkg::OP_RESIZE, 8, 500);
    queue_request(ffpa_pkg::OP_RESIZE, 0, 30);
    queue_request(ffpa_pkg::OP_NONE, 16'h5555, 17'h1FFFF);
    queue_request(ffpa_pkg::OP_ALLOC, 0, PoolBytes);
    queue_request(ffpa_pkg::OP_FREE, 24, 0);
    queue_request(ffpa_pkg::OP_RESIZE, live_offset(), 40000);
    queue_request(ffpa_pkg::OP_ALLOC, 0, 50000);
    while (blk_cnt != 0) queue_request(ffpa_pkg::OP_FREE, live_offset(), 0);
    queue_request(ffpa_pkg::OP_ALLOC, 0, PoolBytes);
    queue_request(ffpa_pkg::OP_FREE, 8, 0);
    n = pending_q.size();
    foreach (expected_q[i]) staged_q.push_back(expected_q[i]);
    expected_q.delete();

    // Random part, with occasional runs of small allocations to fill the table.
    while (n < 1850) begin
      r = $urandom_range(0, 99);
      if (r < 3 && n + 600 < 1850) begin
        repeat (MaxBlocks + 5 - blk_cnt)
          queue_request(ffpa_pkg::OP_ALLOC, 0, $urandom_range(1, 8));
        repeat ($urandom_range(2, 6))
          queue_request(ffpa_pkg::OP_RESIZE, live_offset(), random_size());
        repeat (blk_cnt) queue_request(ffpa_pkg::OP_FREE, live_offset(), 0);
      end else if (r < 45) begin
        queue_request(ffpa_pkg::OP_ALLOC, 0, random_size());
      end else if (r < 68) begin
        off = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : live_offset();
        queue_request(ffpa_pkg::OP_FREE, off, 0);
      end else if (r < 96) begin
        r = $urandom_range(0, 19);
        off = (r == 0) ? 0 : (r == 1) ? $urandom_range(1, 65535) : live_offset();
        queue_request(ffpa_pkg::OP_RESIZE, off, random_size());
      end else begin
        queue_request(ffpa_pkg::OP_NONE, $urandom_range(0, 65535), $urandom_range(0, 131071));
      end
      n = pending_q.size();
      while (expected_q.size() != 0) staged_q.push_back(expected_q.pop_front());
    end
    stimulus_done = 1'b1;

    // Drain, then allow for the block's own latency.
    wait (pending_q.size() == 0 && staged_q.size() == 0 && check_q.size() == 0);
    repeat (2200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
